>>> hdl/assert_macros.svh
// assertion helpers for the grid tracker checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/tgdt_pkg.sv
// ----------------------------------------------------------------------------
// tgdt_pkg
// types and codes shared by the text grid dirty tracker and its checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgdt_pkg;

    localparam logic [3:0] ACT_READ     = 4'd0;
    localparam logic [3:0] ACT_WRITE    = 4'd1;
    localparam logic [3:0] ACT_CUR_MOVE = 4'd2;
    localparam logic [3:0] ACT_CUR_SHOW = 4'd3;
    localparam logic [3:0] ACT_INSERT   = 4'd4;
    localparam logic [3:0] ACT_PTR_MOVE = 4'd5;
    localparam logic [3:0] ACT_PTR_SHOW = 4'd6;
    localparam logic [3:0] ACT_MARK_ALL = 4'd7;
    localparam logic [3:0] ACT_SCAN     = 4'd8;

    localparam int FL_CUR_VIS = 0;
    localparam int FL_INSERT  = 1;
    localparam int FL_PTR_VIS = 2;
    localparam int FL_CUR_CHG = 3;
    localparam int FL_PTR_CHG = 4;

    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [5:0] ROWS_RESET = 6'd25;
    localparam logic [6:0] PTR_COL_RESET = 7'd40;
    localparam logic [4:0] PTR_ROW_RESET = 5'd12;
    localparam logic [7:0] COLS_MAX = 8'd128;
    localparam logic [5:0] ROWS_MAX = 6'd32;
    localparam int GRID_CELLS = 4096;

    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [7:0]  char_value;
        logic [7:0]  attr_value;
        logic [2:0]  write_mask;
        logic        flag_value;
        logic [12:0] scan_handle;
    } t_in_item;

    typedef struct packed {
        logic        status_ok;
        logic [7:0]  char_out;
        logic [7:0]  attr_out;
        logic [6:0]  found_x;
        logic [4:0]  found_y;
        logic [12:0] next_handle;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [6:0]  pointer_col;
        logic [4:0]  pointer_row;
        logic [4:0]  marker_flags;
    } t_out_item;

endpackage

>>> hdl/text_grid_dirty_tracker.sv
// read, write: EXEC, RDW if in range, FIN; marker: EXEC, MARK2 if a shown mark moves, FIN
// scan: EXEC, DIV for the handle's row, SRD, SCHK per slot visited via the dirty memory port
// mark all (flag_value): SWEEP writes every slot in the grid, one dirty memory write each
// one item at a time, accepted only in ST_IDLE; the next item is taken
// while the last result waits
// reset (synchronous, active low) starts a clearing pass that marks all dirty and zeroes the cells
// ----------------------------------------------------------------------------
// text_grid_dirty_tracker
// character cell grid with dirty marks, cursor, pointer and dirty scan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_grid_dirty_tracker
    import tgdt_pkg::*;
#(
    parameter int MAX_CELLS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_CELLS);
    localparam int NCAP = (MAX_CELLS > GRID_CELLS) ? GRID_CELLS : MAX_CELLS;

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_EXEC  = 4'd2;
    localparam logic [3:0] ST_RDW   = 4'd3;
    localparam logic [3:0] ST_MARK2 = 4'd4;
    localparam logic [3:0] ST_SWEEP = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_SRD   = 4'd7;
    localparam logic [3:0] ST_SCHK  = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    logic [15:0] cell_mem [MAX_CELLS];
    logic        dirty_mem [MAX_CELLS];

    logic [3:0]  r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    t_in_item    r_in, n_in;
    logic [7:0]  r_cols, n_cols;
    logic [5:0]  r_rows, n_rows;
    logic [6:0]  r_cur_col, n_cur_col, r_ptr_col, n_ptr_col;
    logic [4:0]  r_cur_row, n_cur_row, r_ptr_row, n_ptr_row;
    logic [4:0]  r_flags, n_flags;
    logic        r_ok, n_ok;
    logic [7:0]  r_cout, n_cout, r_aout, n_aout;
    logic [6:0]  r_fx, n_fx;
    logic [4:0]  r_fy, n_fy;
    logic [12:0] r_nh, n_nh;
    logic [12:0] r_i, n_i;
    logic [12:0] r_rem, n_rem;
    logic        r_ov, n_ov;
    t_out_item   r_out, n_out;
    logic [15:0] r_cell_q;
    logic        r_dirty_q;

    logic [7:0]  ecols;
    logic [5:0]  erows;
    logic [12:0] prod;
    logic [12:0] slot_n;
    logic        loc_ok, mk_ok;
    logic [12:0] loc_s, mk_s;
    logic [6:0]  mk_col;
    logic [4:0]  mk_row;
    logic        is_cur;
    logic        cfg_wr;

    logic          cw_en, dw_en, dw_data;
    logic [AW-1:0] cw_addr, dw_addr, dr_addr;
    logic [15:0]   cw_data;
    logic [15:0]   old_cell, new_cell;
    logic [7:0]    nc, na;

    assign ecols = (r_cols == 8'd0) ? 8'd1 : ((r_cols > COLS_MAX) ? COLS_MAX : r_cols);
    assign erows = (r_rows == 6'd0) ? 6'd1 : ((r_rows > ROWS_MAX) ? ROWS_MAX : r_rows);
    assign prod = 13'(ecols * erows);
    assign slot_n = (32'(prod) > 32'(NCAP)) ? 13'(NCAP) : prod;

    assign loc_s = 13'(r_in.pos_y[4:0] * ecols) + 13'(r_in.pos_x[6:0]);
    assign loc_ok = (r_in.pos_x < ecols) && (r_in.pos_y < 8'(erows)) && (loc_s < slot_n);

    assign is_cur = (r_in.action == ACT_CUR_MOVE) || (r_in.action == ACT_CUR_SHOW)
                 || (r_in.action == ACT_INSERT);
    assign mk_col = is_cur ? r_cur_col : r_ptr_col;
    assign mk_row = is_cur ? r_cur_row : r_ptr_row;
    assign mk_s = 13'(mk_row * ecols) + 13'(mk_col);
    assign mk_ok = ({1'b0, mk_col} < ecols) && ({1'b0, mk_row} < 6'(erows)) && (mk_s < slot_n);

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROWS) ? {26'd0, r_rows} : {24'd0, r_cols};

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_item = r_out;

    assign old_cell = r_cell_q;
    always_comb begin
        nc = r_in.write_mask[0] ? r_in.char_value : old_cell[7:0];
        na = old_cell[15:8];
        if (r_in.write_mask[1]) begin
            na[3:0] = r_in.attr_value[3:0];
        end
        if (r_in.write_mask[2]) begin
            na[7:4] = r_in.attr_value[7:4];
        end
        new_cell = {na, nc};
    end

    assign dr_addr = (r_state == ST_SCHK) ? AW'(r_i + 13'd1) : AW'(r_i);

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_in = r_in;
        n_cols = r_cols;
        n_rows = r_rows;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_ptr_col = r_ptr_col;
        n_ptr_row = r_ptr_row;
        n_flags = r_flags;
        n_ok = r_ok;
        n_cout = r_cout;
        n_aout = r_aout;
        n_fx = r_fx;
        n_fy = r_fy;
        n_nh = r_nh;
        n_i = r_i;
        n_rem = r_rem;
        n_ov = r_ov;
        n_out = r_out;
        cw_en = 1'b0;
        cw_addr = AW'(loc_s);
        cw_data = new_cell;
        dw_en = 1'b0;
        dw_addr = AW'(loc_s);
        dw_data = 1'b1;

        if (cfg_wr) begin
            unique case (paddr[2])
                REG_COLUMNS: n_cols = pwdata[7:0];
                REG_ROWS:    n_rows = pwdata[5:0];
                default: ;
            endcase
        end

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            ST_CLR: begin
                cw_en = 1'b1;
                cw_addr = r_clr;
                cw_data = 16'd0;
                dw_en = 1'b1;
                dw_addr = r_clr;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(MAX_CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_in = i_in_item;
                    n_ok = 1'b0;
                    n_cout = 8'd0;
                    n_aout = 8'd0;
                    n_fx = 7'd0;
                    n_fy = 5'd0;
                    n_nh = 13'd0;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_FIN;
                unique case (r_in.action) inside
                    ACT_READ, ACT_WRITE: begin
                        if (loc_ok) begin
                            n_state = ST_RDW;
                        end
                    end
                    ACT_CUR_MOVE, ACT_PTR_MOVE: begin
                        if (loc_ok) begin
                            n_ok = 1'b1;
                            if (r_in.pos_x != {1'b0, mk_col} || r_in.pos_y != {3'd0, mk_row})
                            begin
                                if (r_flags[is_cur ? FL_CUR_VIS : FL_PTR_VIS]) begin
                                    dw_en = mk_ok;
                                    dw_addr = AW'(mk_s);
                                    n_state = ST_MARK2;
                                end
                                if (is_cur) begin
                                    n_flags[FL_CUR_CHG] = 1'b1;
                                    n_cur_col = r_in.pos_x[6:0];
                                    n_cur_row = r_in.pos_y[4:0];
                                end else begin
                                    n_flags[FL_PTR_CHG] = 1'b1;
                                    n_ptr_col = r_in.pos_x[6:0];
                                    n_ptr_row = r_in.pos_y[4:0];
                                end
                                if (r_cur_col == r_ptr_col && r_cur_row == r_ptr_row) begin
                                    n_flags[is_cur ? FL_PTR_CHG : FL_CUR_CHG] = 1'b1;
                                end
                            end
                        end
                    end
                    ACT_CUR_SHOW, ACT_INSERT, ACT_PTR_SHOW: begin
                        dw_en = mk_ok;
                        dw_addr = AW'(mk_s);
                        n_ok = 1'b1;
                        if (r_in.action == ACT_CUR_SHOW) begin
                            n_flags[FL_CUR_VIS] = r_in.flag_value;
                            n_flags[FL_CUR_CHG] = 1'b1;
                        end else if (r_in.action == ACT_INSERT) begin
                            n_flags[FL_INSERT] = r_in.flag_value;
                            n_flags[FL_CUR_CHG] = 1'b1;
                        end else begin
                            n_flags[FL_PTR_VIS] = r_in.flag_value;
                            n_flags[FL_PTR_CHG] = 1'b1;
                        end
                    end
                    ACT_MARK_ALL: begin
                        n_ok = 1'b1;
                        n_flags[FL_CUR_CHG] = r_in.flag_value;
                        n_flags[FL_PTR_CHG] = r_in.flag_value;
                        n_i = 13'd0;
                        n_state = ST_SWEEP;
                    end
                    ACT_SCAN: begin
                        if (r_in.scan_handle >= slot_n) begin
                            n_nh = r_in.scan_handle;
                        end else begin
                            n_i = r_in.scan_handle;
                            n_rem = r_in.scan_handle;
                            n_fy = 5'd0;
                            n_state = ST_DIV;
                        end
                    end
                    default: ;
                endcase
            end
            ST_RDW: begin
                n_ok = 1'b1;
                if (r_in.action == ACT_READ) begin
                    n_cout = old_cell[7:0];
                    n_aout = old_cell[15:8];
                end else if (new_cell != old_cell) begin
                    cw_en = 1'b1;
                    dw_en = 1'b1;
                end
                n_state = ST_FIN;
            end
            ST_MARK2: begin
                dw_en = 1'b1;
                n_state = ST_FIN;
            end
            ST_SWEEP: begin
                dw_en = 1'b1;
                dw_addr = AW'(r_i);
                dw_data = r_in.flag_value;
                n_i = r_i + 13'd1;
                if (r_i == slot_n - 13'd1) begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                if (r_rem >= 13'(ecols)) begin
                    n_rem = r_rem - 13'(ecols);
                    n_fy = r_fy + 5'd1;
                end else begin
                    n_fx = r_rem[6:0];
                    n_state = ST_SRD;
                end
            end
            ST_SRD: begin
                n_state = ST_SCHK;
            end
            ST_SCHK: begin
                if (r_dirty_q) begin
                    n_ok = 1'b1;
                    n_nh = r_i + 13'd1;
                    n_state = ST_FIN;
                end else if (r_i + 13'd1 >= slot_n) begin
                    n_nh = slot_n;
                    n_fx = 7'd0;
                    n_fy = 5'd0;
                    n_state = ST_FIN;
                end else begin
                    n_i = r_i + 13'd1;
                    if (8'(r_fx) + 8'd1 == ecols) begin
                        n_fx = 7'd0;
                        n_fy = r_fy + 5'd1;
                    end else begin
                        n_fx = r_fx + 7'd1;
                    end
                end
            end
            ST_FIN: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov = 1'b1;
                    n_out.status_ok = r_ok;
                    n_out.char_out = r_cout;
                    n_out.attr_out = r_aout;
                    n_out.found_x = r_fx;
                    n_out.found_y = r_fy;
                    n_out.next_handle = r_nh;
                    n_out.cursor_col = r_cur_col;
                    n_out.cursor_row = r_cur_row;
                    n_out.pointer_col = r_ptr_col;
                    n_out.pointer_row = r_ptr_row;
                    n_out.marker_flags = r_flags;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cw_en) begin
            cell_mem[cw_addr] <= cw_data;
        end
        r_cell_q <= cell_mem[AW'(loc_s)];
    end

    always_ff @(posedge i_clk) begin
        if (dw_en) begin
            dirty_mem[dw_addr] <= dw_data;
        end
        r_dirty_q <= dirty_mem[dr_addr];
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
        r_ok <= n_ok;
        r_cout <= n_cout;
        r_aout <= n_aout;
        r_fx <= n_fx;
        r_fy <= n_fy;
        r_nh <= n_nh;
        r_i <= n_i;
        r_rem <= n_rem;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr <= '0;
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
            r_cur_col <= 7'd0;
            r_cur_row <= 5'd0;
            r_ptr_col <= PTR_COL_RESET;
            r_ptr_row <= PTR_ROW_RESET;
            r_flags <= 5'b11101;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_cols <= n_cols;
            r_rows <= n_rows;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_ptr_col <= n_ptr_col;
            r_ptr_row <= n_ptr_row;
            r_flags <= n_flags;
            r_ov <= n_ov;
        end
    end

endmodule

>>> hdl/tgdt_checker.sv
// ----------------------------------------------------------------------------
// tgdt_checker
// port-level checks for the text grid dirty tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tgdt_checker
    import tgdt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `ASSERT_IMPLIES(a_read_data_ok, i_clk, i_rst_n, o_out_valid && (o_out_item.char_out != 8'd0 || o_out_item.attr_out != 8'd0), o_out_item.status_ok)
    `ASSERT_IMPLIES(a_found_ok, i_clk, i_rst_n, o_out_valid && (o_out_item.found_x != 7'd0 || o_out_item.found_y != 5'd0), o_out_item.status_ok)

endmodule

bind text_grid_dirty_tracker tgdt_checker u_tgdt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
